/* src/tle_pkg.sv */
// ----------------------------------------------------------------------------
// Terminal line editor package
// Shared types, character codes and the erase sequence of the line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package tle_pkg;

    // Character codes recognized by the editor.
    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_DEL  = 8'h7f;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Line status codes.
    localparam logic [1:0] ST_CONT     = 2'd0;
    localparam logic [1:0] ST_RETURN   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Register map.
    localparam int        ADDR_W        = 3;
    localparam logic      REG_LINE_LIMIT = 1'b0;
    localparam logic [8:0] LIMIT_RESET  = 9'd256;

    // Erase sequence: cursor left, then erase to end of line.
    localparam logic [2:0] ERASE_LAST = 3'd5;

    // Escape parser state.
    typedef enum logic [2:0] {
        ESC_IDLE  = 3'b001,
        ESC_SEEN  = 3'b010,
        ESC_PARAM = 3'b100
    } t_esc;

    // Fields of one result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       store_valid;
        logic [7:0] store_index;
        logic [1:0] line_status;
        logic [8:0] line_length;
    } t_item;

    // What an input byte asks of the output stage.
    typedef struct packed {
        logic  emit;
        logic  erase;
        t_item item;
    } t_desc;

    // Byte k of the erase sequence ESC [ D ESC [ K.
    function automatic logic [7:0] erase_byte(input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = CH_ESC;
            3'd1:    b = 8'h5b;
            3'd2:    b = 8'h44;
            3'd3:    b = CH_ESC;
            3'd4:    b = 8'h5b;
            3'd5:    b = 8'h4b;
            default: b = CH_ESC;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* src/tle_decode.sv */
// ----------------------------------------------------------------------------
// Terminal line editor byte decoder
// Classifies one received byte against the line and escape state and gives
// the next state together with the result it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_decode #(
    parameter int CNT_W   = 8,
    parameter int LIM_W   = 9,
    parameter int LIM_CAP = 256
) (
    input  wire logic [7:0]       i_byte,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire tle_pkg::t_esc    i_phase,
    input  wire logic [8:0]       i_limit,
    output logic [CNT_W-1:0]      o_count,
    output tle_pkg::t_esc         o_phase,
    output tle_pkg::t_desc        o_desc
);
    import tle_pkg::*;

    logic [LIM_W-1:0] eff_limit;
    logic [LIM_W-1:0] count_inc;
    logic [CNT_W-1:0] count_dec;
    logic             is_param;
    logic             overflow;

    // Effective limit: zero acts as one, large values clamp to the line size.
    always_comb begin
        if (i_limit == 9'd0) begin
            eff_limit = LIM_W'(1);
        end else if (32'(i_limit) > LIM_CAP) begin
            eff_limit = LIM_W'(LIM_CAP);
        end else begin
            eff_limit = LIM_W'(i_limit);
        end
    end

    assign count_inc = LIM_W'(i_count) + LIM_W'(1);
    assign count_dec = i_count - CNT_W'(1);
    assign overflow  = (count_inc >= eff_limit);
    assign is_param  = ((i_byte >= CH_ZERO) && (i_byte <= CH_NINE)) || (i_byte == CH_SEMI);

    // Byte classification and state update.
    always_comb begin
        o_count = i_count;
        o_phase = i_phase;
        o_desc  = '0;
        case (i_phase)
            ESC_SEEN: begin
                o_phase = ESC_PARAM;
            end
            ESC_PARAM: begin
                if (!is_param) begin
                    o_phase = ESC_IDLE;
                end
            end
            default: begin
                if (i_byte == CH_ESC) begin
                    o_phase = ESC_SEEN;
                end else if ((i_byte == CH_BS) || (i_byte == CH_DEL)) begin
                    // Erase only shortens a line that holds something.
                    if (i_count != '0) begin
                        o_count                  = count_dec;
                        o_desc.emit              = 1'b1;
                        o_desc.erase             = 1'b1;
                        o_desc.item.line_status  = ST_CONT;
                        o_desc.item.line_length  = 9'(count_dec);
                    end
                end else if (i_byte == CH_CR) begin
                    o_count                  = '0;
                    o_desc.emit              = 1'b1;
                    o_desc.item.out_byte     = CH_LF;
                    o_desc.item.line_status  = ST_RETURN;
                    o_desc.item.line_length  = 9'(i_count);
                end else begin
                    // Ordinary character: stored at the current position.
                    o_count                  = overflow ? '0 : CNT_W'(count_inc);
                    o_desc.emit              = 1'b1;
                    o_desc.item.out_byte     = i_byte;
                    o_desc.item.store_valid  = 1'b1;
                    o_desc.item.store_index  = 8'(i_count);
                    o_desc.item.line_status  = overflow ? ST_OVERFLOW : ST_CONT;
                    o_desc.item.line_length  = 9'(count_inc);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/tle_emitter.sv */
// ----------------------------------------------------------------------------
// Terminal line editor output stage
// Result register that shows one item per cycle while the output is not
// stalled, and steps through the six bytes of the erase sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_emitter (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire tle_pkg::t_desc i_desc,
    output logic                o_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_store_valid,
    output logic [7:0]          o_store_index,
    output logic [1:0]          o_line_status,
    output logic [8:0]          o_line_length,
    output logic                o_last
);
    import tle_pkg::*;

    logic       r_busy;
    logic       r_erase;
    logic [2:0] r_step;
    t_item      r_item;
    logic       take;
    logic       final_beat;

    assign take       = r_busy && !i_out_stall;
    assign final_beat = !r_erase || (r_step == ERASE_LAST);
    assign o_ready    = !r_busy || (take && final_beat);

    // Control: busy flag and erase step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_erase <= 1'b0;
            r_step  <= 3'd0;
        end else if (i_load) begin
            r_busy  <= 1'b1;
            r_erase <= i_desc.erase;
            r_step  <= 3'd0;
        end else if (take) begin
            if (final_beat) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    // Payload of the held result.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_desc.item;
        end
    end

    // Output fields.
    assign o_out_valid   = r_busy;
    assign o_out_byte    = r_erase ? erase_byte(r_step) : r_item.out_byte;
    assign o_store_valid = r_item.store_valid;
    assign o_store_index = r_item.store_index;
    assign o_line_status = r_item.line_status;
    assign o_line_length = r_item.line_length;
    assign o_last        = final_beat;

    // A new result is loaded only when the held one is gone or leaving.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("result loaded over a pending result");

    // An erase sequence continues without a gap once a beat is taken.
    a_erase_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !final_beat) |=> (o_out_valid && r_erase))
        else $error("erase sequence broken off");

    // The erase bytes never claim a stored character.
    a_erase_nostore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_erase) |-> !o_store_valid)
        else $error("erase byte marked as stored");

endmodule

`default_nettype wire

/* src/terminal_line_editor_unit.sv */
// ----------------------------------------------------------------------------
// Terminal line editor
// Canonical-mode line editing: echo, erase, return, overflow and escape
// sequence swallowing for one received byte per item.
// ----------------------------------------------------------------------------
// Results are registered: one appears in the cycle after its item is accepted.
// Throughput: one item per cycle when each gives at most one result and the
// output is not stalled; an erase gives six results and stalls the input
// while the single output register steps through the sequence.
// Reset: line length zero, escape parser idle, line_limit 256, output empty.
`default_nettype none

module terminal_line_editor_unit #(
    parameter int LINE_MAX = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [7:0]               i_in_byte,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_store_valid,
    output logic [7:0]                    o_store_index,
    output logic [1:0]                    o_line_status,
    output logic [8:0]                    o_line_length,
    output logic                          o_last,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [tle_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tle_pkg::*;

    // Counts stay below the effective limit, which the 9-bit register bounds.
    localparam int CNT_W   = (LINE_MAX >= 512) ? 9 : $clog2(LINE_MAX);
    localparam int LIM_W   = CNT_W + 1;
    localparam int LIM_CAP = (LINE_MAX > 511) ? 511 : LINE_MAX;

    logic [8:0]       r_limit;
    logic [CNT_W-1:0] r_count;
    t_esc             r_phase;
    logic [CNT_W-1:0] n_count;
    t_esc             n_phase;
    t_desc            desc;
    logic             emit_ready;
    logic             in_accept;
    logic             cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_LINE_LIMIT);
    assign prdata    = (paddr[2] == REG_LINE_LIMIT) ? {23'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (cfg_write) begin
            r_limit <= pwdata[8:0];
        end
    end

    // Input handshake: an item is taken whenever the result register is free or its final byte is being taken.
    assign o_in_stall = !emit_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    tle_decode #(
        .CNT_W   (CNT_W),
        .LIM_W   (LIM_W),
        .LIM_CAP (LIM_CAP)
    ) u_decode (
        .i_byte  (i_in_byte),
        .i_count (r_count),
        .i_phase (r_phase),
        .i_limit (r_limit),
        .o_count (n_count),
        .o_phase (n_phase),
        .o_desc  (desc)
    );

    // Line and escape state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= ESC_IDLE;
        end else if (in_accept) begin
            r_count <= n_count;
            r_phase <= n_phase;
        end
    end

    tle_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (in_accept && desc.emit),
        .i_desc        (desc),
        .o_ready       (emit_ready),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_store_valid (o_store_valid),
        .o_store_index (o_store_index),
        .o_line_status (o_line_status),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire
